// ===== rtl/core/jacobi_relaxation_stencil_sweep_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef JACOBI_RELAXATION_STENCIL_SWEEP_MACROS_SVH
`define JACOBI_RELAXATION_STENCIL_SWEEP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define JRS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define JRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/jrs_pkg.sv =====
package jrs_pkg;

	localparam int MAX_GRID  = 1024;
	localparam int MIN_GRID  = 4;
	localparam int DATA_BITS = 32;
	localparam int IDX_W     = $clog2(MAX_GRID);
	localparam int SIZE_W    = IDX_W + 1;
	localparam int WEIGHT_W  = 18;
	localparam int FRAC_W    = 16;

	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(64);
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(58982);

	typedef enum logic [0:0] {
		REG_GRID_SIZE    = 1'b0,
		REG_RELAX_WEIGHT = 1'b1
	} jrs_reg_t;

	// Sweep control handed from the register block to the front end.
	typedef struct packed {
		logic             restart;
		logic [IDX_W-1:0] last_idx;
	} jrs_cfg_t;

	// One stencil job: everything the back end needs for point (row-1, col),
	// plus the copy of point (row, col) on the last row.
	typedef struct packed {
		logic [DATA_BITS-1:0] x;
		logic [DATA_BITS-1:0] up;
		logic [DATA_BITS-1:0] ctr;
		logic [DATA_BITS-1:0] left;
		logic [DATA_BITS-1:0] right;
		logic [IDX_W-1:0]     row;
		logic [IDX_W-1:0]     col;
		logic                 upper_copy;
		logic                 emit_lower;
		logic                 last;
	} jrs_item_t;

endpackage

// ===== rtl/core/jrs_ram.sv =====
module jrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old word when both ports hit one address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/jrs_fifo.sv =====
module jrs_fifo
	import jrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jrs_item_t         push_item,
	input  logic              pop,
	output jrs_item_t         pop_item,
	output logic              nonempty,
	output logic [QCNT_W-1:0] level
);

	jrs_item_t         entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	assign pop_item = entry_q[rd_ptr_q];
	assign nonempty = (level_q != '0);
	assign level    = level_q;

endmodule

// ===== rtl/core/jrs_front.sv =====
module jrs_front
	import jrs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  jrs_cfg_t             cfg,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic [DATA_BITS-1:0] sample,
	input  logic [QCNT_W-1:0]    q_level,
	output logic                 push,
	output jrs_item_t            push_item
);

	logic                 accept;
	logic                 at_last_col;
	logic                 at_last_row;
	logic [IDX_W-1:0]     row_q;
	logic [IDX_W-1:0]     col_q;
	logic [IDX_W-1:0]     ahead_addr;

	logic                 valid_s1;
	logic [DATA_BITS-1:0] x_s1;
	logic [IDX_W-1:0]     row_s1;
	logic [IDX_W-1:0]     col_s1;
	logic                 upper_s1;
	logic                 copy_s1;
	logic                 lower_s1;
	logic                 last_s1;

	logic [DATA_BITS-1:0] ctr_q;
	logic [DATA_BITS-1:0] left_q;
	logic [DATA_BITS-1:0] newer_rd;
	logic [DATA_BITS-1:0] older_rd;

	// Room for the item in flight plus the one accepted now.
	assign sample_stall = (q_level + QCNT_W'(valid_s1)) >= QCNT_W'(QDEPTH);
	assign accept       = sample_valid && !sample_stall;
	assign at_last_col  = (col_q == cfg.last_idx);
	assign at_last_row  = (row_q == cfg.last_idx);
	// Look one column ahead; wrap to column 0 so it primes the next row's centre.
	assign ahead_addr   = at_last_col ? '0 : col_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (cfg.restart) begin
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				if (at_last_col) begin
					col_q <= '0;
					row_q <= at_last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= sample;
			row_s1   <= row_q;
			col_s1   <= col_q;
			upper_s1 <= (row_q != '0);
			copy_s1  <= (row_q == IDX_W'(1)) || (col_q == '0) || at_last_col;
			lower_s1 <= at_last_row;
			last_s1  <= at_last_row && at_last_col;
		end
		// Slide the centre row window: right becomes centre, centre becomes left.
		if (valid_s1) begin
			ctr_q  <= newer_rd;
			left_q <= ctr_q;
		end
	end

	// Newest complete row: take the sample at its column.
	jrs_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (MAX_GRID)
	) u_newer (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (sample),
		.re    (accept),
		.raddr (ahead_addr),
		.rdata (newer_rd)
	);

	// Row above that: takes the centre value once it leaves the newer row.
	jrs_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (MAX_GRID)
	) u_older (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (ctr_q),
		.re    (accept),
		.raddr (col_q),
		.rdata (older_rd)
	);

	// Drop first-row samples: they finish no point.
	assign push = valid_s1 && upper_s1;

	always_comb begin
		push_item            = '0;
		push_item.x          = x_s1;
		push_item.up         = older_rd;
		push_item.ctr        = ctr_q;
		push_item.left       = left_q;
		push_item.right      = newer_rd;
		push_item.row        = row_s1;
		push_item.col        = col_s1;
		push_item.upper_copy = copy_s1;
		push_item.emit_lower = lower_s1;
		push_item.last       = last_s1;
	end

endmodule

// ===== rtl/core/jrs_back.sv =====
module jrs_back
	import jrs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [WEIGHT_W-1:0]  weight,
	input  logic                 q_valid,
	input  jrs_item_t            q_item,
	output logic                 q_pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [DATA_BITS-1:0] value,
	output logic [IDX_W-1:0]     row,
	output logic [IDX_W-1:0]     col,
	output logic                 last
);

	localparam int SUM_W  = DATA_BITS + 2;
	localparam int DIFF_W = DATA_BITS + 1;
	localparam int PROD_W = DIFF_W + WEIGHT_W + 1;
	localparam int SH_W   = PROD_W - FRAC_W;
	localparam int TOT_W  = SH_W + 1;

	logic out_free;
	logic adv;

	logic                     valid_s1;
	logic                     valid_s2;
	logic                     valid_s3;
	jrs_item_t                item_s1;
	jrs_item_t                item_s2;
	jrs_item_t                item_s3;
	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [PROD_W-1:0] prod_s3;

	logic        [SUM_W-1:0]  nb_sum;
	logic        [DIFF_W-1:0] diff;
	logic signed [SH_W-1:0]   prod_sh;
	logic signed [TOT_W-1:0]  total;
	logic [DATA_BITS-1:0]     relaxed;
	logic [DATA_BITS-1:0]     upper_value;

	logic                 res_valid_q;
	logic [DATA_BITS-1:0] value_q;
	logic [IDX_W-1:0]     row_q;
	logic [IDX_W-1:0]     col_q;
	logic                 last_q;
	logic                 pend_q;
	logic [DATA_BITS-1:0] pend_value_q;
	logic [IDX_W-1:0]     pend_row_q;
	logic [IDX_W-1:0]     pend_col_q;
	logic                 pend_last_q;

	assign out_free = !res_valid_q || !result_stall;
	// Freeze the pipe while the output is stalled or the second result of a last-row item waits.
	assign adv      = !pend_q && out_free;
	assign q_pop    = adv && q_valid;

	// Neighbor sum, floor divide by four, minus centre.
	always_comb begin
		nb_sum = {{2{item_s1.up[DATA_BITS-1]}}, item_s1.up}
			+ {{2{item_s1.x[DATA_BITS-1]}}, item_s1.x}
			+ {{2{item_s1.left[DATA_BITS-1]}}, item_s1.left}
			+ {{2{item_s1.right[DATA_BITS-1]}}, item_s1.right};
		diff = {nb_sum[SUM_W-1], nb_sum[SUM_W-1:2]}
			- {item_s1.ctr[DATA_BITS-1], item_s1.ctr};
	end

	// Floor shift of the product, add centre, saturate.
	always_comb begin
		prod_sh = prod_s3[PROD_W-1:FRAC_W];
		total   = $signed({{(TOT_W-DATA_BITS){item_s3.ctr[DATA_BITS-1]}}, item_s3.ctr})
			+ $signed({prod_sh[SH_W-1], prod_sh});
		if (total[TOT_W-1:DATA_BITS-1] == '0 || total[TOT_W-1:DATA_BITS-1] == '1) begin
			relaxed = total[DATA_BITS-1:0];
		end else if (total[TOT_W-1]) begin
			relaxed = {1'b1, {(DATA_BITS-1){1'b0}}};
		end else begin
			relaxed = {1'b0, {(DATA_BITS-1){1'b1}}};
		end
		upper_value = item_s3.upper_copy ? item_s3.ctr : relaxed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= q_pop;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
			end
			if (pend_q) begin
				if (out_free) begin
					res_valid_q <= 1'b1;
					pend_q      <= 1'b0;
				end
			end else if (adv) begin
				res_valid_q <= valid_s3;
				pend_q      <= valid_s3 && item_s3.emit_lower;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= q_item;
			item_s2 <= item_s1;
			diff_s2 <= $signed(diff);
			item_s3 <= item_s2;
			prod_s3 <= $signed({1'b0, weight}) * diff_s2;
		end
		if (pend_q) begin
			if (out_free) begin
				value_q <= pend_value_q;
				row_q   <= pend_row_q;
				col_q   <= pend_col_q;
				last_q  <= pend_last_q;
			end
		end else if (adv && valid_s3) begin
			value_q      <= upper_value;
			row_q        <= item_s3.row - 1'b1;
			col_q        <= item_s3.col;
			last_q       <= 1'b0;
			pend_value_q <= item_s3.x;
			pend_row_q   <= item_s3.row;
			pend_col_q   <= item_s3.col;
			pend_last_q  <= item_s3.last;
		end
	end

	assign result_valid = res_valid_q;
	assign value        = value_q;
	assign row          = row_q;
	assign col          = col_q;
	assign last         = last_q;

endmodule

// ===== rtl/core/jacobi_relaxation_stencil_sweep.sv =====
// One weighted-Jacobi sweep over an N x N grid of signed Q16.16 samples that
// arrive in raster order. Once a sample of row r >= 1 is taken, the block has
// all five stencil points of (r-1, c) and emits that point: border points are
// copied, interior points become s + omega * (((up+down+left+right) >>> 2) - s),
// with floor shifts and 32-bit saturation. Points of the last row are also
// emitted as copies right after the point above them, so that row produces two
// results per sample; the first row produces none. The sweep takes one sample
// per clock while sample_stall is low, and the result channel moves one result
// per clock while result_stall is low, so on the last row the output port bounds
// the sample rate. A sample's results pass through one front-end stage, the job
// queue, three arithmetic stages and the output register. The two most recent
// rows live in two 1024 x 32 single-port-read RAMs that need no clearing: a value
// read from an entry the sweep has not yet written never reaches a result.
// Registers: grid_size at byte 0 (clamped to 4..1024 in use; a write restarts
// the sweep at row 0, column 0, keeping the row stores), relax_weight at
// byte 4 (unsigned Q2.16, applied as written). Write them only while idle.
module jacobi_relaxation_stencil_sweep
	import jrs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Sample channel
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic [DATA_BITS-1:0] sample,
	// Result channel
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [DATA_BITS-1:0] value,
	output logic [IDX_W-1:0]     row,
	output logic [IDX_W-1:0]     col,
	output logic                 last,
	// Register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	logic [SIZE_W-1:0]   grid_size_q;
	logic [WEIGHT_W-1:0] relax_weight_q;
	logic [SIZE_W-1:0]   side;
	logic                cfg_write;
	jrs_reg_t            reg_sel;
	jrs_cfg_t            cfg;

	logic                q_push;
	jrs_item_t           q_push_item;
	logic                q_pop;
	jrs_item_t           q_pop_item;
	logic                q_nonempty;
	logic [QCNT_W-1:0]   q_level;

	// Register block: every access completes in its access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_sel   = jrs_reg_t'(paddr[PADDR_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q    <= SIZE_RESET;
			relax_weight_q <= WEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_GRID_SIZE:    grid_size_q    <= pwdata[SIZE_W-1:0];
				REG_RELAX_WEIGHT: relax_weight_q <= pwdata[WEIGHT_W-1:0];
				default:          grid_size_q    <= grid_size_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_GRID_SIZE:    prdata = PDATA_W'(grid_size_q);
			REG_RELAX_WEIGHT: prdata = PDATA_W'(relax_weight_q);
			default:          prdata = '0;
		endcase
	end

	// Clamp the side length to the supported range.
	always_comb begin
		if (grid_size_q < SIZE_W'(MIN_GRID)) begin
			side = SIZE_W'(MIN_GRID);
		end else if (grid_size_q > SIZE_W'(MAX_GRID)) begin
			side = SIZE_W'(MAX_GRID);
		end else begin
			side = grid_size_q;
		end
		cfg.last_idx = IDX_W'(side - 1'b1);
		cfg.restart  = cfg_write && (reg_sel == REG_GRID_SIZE);
	end

	// Front end: raster position, row stores, stencil gather.
	jrs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.q_level      (q_level),
		.push         (q_push),
		.push_item    (q_push_item)
	);

	// Job queue decouples the gather from the arithmetic and output stalls.
	jrs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.pop_item  (q_pop_item),
		.nonempty  (q_nonempty),
		.level     (q_level)
	);

	// Back end: relaxation arithmetic and result sequencing.
	jrs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.weight       (relax_weight_q),
		.q_valid      (q_nonempty),
		.q_item       (q_pop_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.row          (row),
		.col          (col),
		.last         (last)
	);

endmodule

// ===== rtl/core/jrs_checker.sv =====
`include "jacobi_relaxation_stencil_sweep_macros.svh"

module jrs_checker
	import jrs_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 sample_valid,
	input logic                 sample_stall,
	input logic [DATA_BITS-1:0] sample,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic [DATA_BITS-1:0] value,
	input logic [IDX_W-1:0]     row,
	input logic [IDX_W-1:0]     col,
	input logic                 last
);

	// Hold a stalled sample.
	`JRS_ASSERT_NEXT(a_sample_hold, sample_valid && sample_stall, sample_valid && $stable(sample), "sample changed while stalled")

	// Hold a stalled result.
	`JRS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(value) && $stable(row) && $stable(col) && $stable(last), "result changed while stalled")

	// The final point sits on the diagonal corner.
	`JRS_ASSERT_SAME(a_last_corner, result_valid && last, row == col, "last flagged off the diagonal")

	// No back-to-back final points: a grid needs many samples between them.
	`JRS_ASSERT_NEXT(a_last_single, result_valid && !result_stall && last, !(result_valid && last), "final point repeated")

endmodule

bind jacobi_relaxation_stencil_sweep jrs_checker u_jrs_checker (.*);
